/* hw/rtl/ordered_array_engine_macros.svh */
// assertion macros used by the checker of the ordered array engine
`ifndef ORDERED_ARRAY_ENGINE_MACROS_SVH
`define ORDERED_ARRAY_ENGINE_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define OAE_ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("oae: same-cycle property violated");

// next-cycle implication
`define OAE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("oae: next-cycle property violated");

`endif

/* hw/rtl/oae_pkg.sv */
`default_nettype none

package oae_pkg;

  localparam int OAE_CAPACITY = 64;

  localparam int OP_W     = 3;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 7;
  localparam int COUNT_W  = 7;

  // position and value, padded to whole bytes
  localparam int IN_TDATA_W  = ((POS_W + VAL_W + 7) / 8) * 8;
  // status, data, found_position, entry_count
  localparam int OUT_TDATA_W = ((STATUS_W + VAL_W + FOUND_W + COUNT_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_DELETE  = 3'd1,
    OP_SEARCH  = 3'd2,
    OP_SUM     = 3'd3,
    OP_DISPLAY = 3'd4
  } oae_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BAD       = 2'd2,
    ST_EMPTY     = 2'd3
  } oae_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_PUT,
    S_FIN,
    S_DISP
  } oae_state_e;

endpackage

`default_nettype wire

/* hw/rtl/ordered_array_engine.sv */
// ordered array engine: a positional array of signed 32-bit entries in one
// synchronous memory with a registered read.
// input channel s_axis: tuser carries the operation (insert, delete, search,
// sum, display); tdata carries position and value. one request is taken at a
// time, s_axis_tready_o is high only while the engine is idle.
// output channel m_axis: tdata carries status, data, found_position and
// entry_count; tlast marks the final item of a request. display gives one
// item per entry, every other request exactly one item.
// insert at position p <= n, delete at p < n, search and sum walk the memory;
// search stops at the first match. an append at n+1, rejected and trivial
// requests (delete of the last entry, search, sum or display of an empty
// array) skip the walk. display reads one entry at a time and issues the next
// read only once the result register is free. the memory port walks one
// entry per cycle.
// a result register decouples the sides: the next request is accepted and
// walks the memory while the previous result still waits. a stall on
// m_axis holds the result and the engine waits before loading a new one.
// reset empties the array at once (count to zero); no clearing pass.
`default_nettype none

module ordered_array_engine #(
  parameter int CAPACITY = oae_pkg::OAE_CAPACITY
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output      logic                           s_axis_tready_o,
  // [6:0] position, [38:7] value, [39] zero
  input  wire logic [oae_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [2:0] operation
  input  wire logic [oae_pkg::OP_W-1:0]        s_axis_tuser_i,
  output      logic                           m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // [1:0] status, [33:2] data, [40:34] found_position, [47:41] entry_count
  output      logic [oae_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output      logic                           m_axis_tlast_o
);
  import oae_pkg::*;

  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int AW1 = AW + 1;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PW  = ((CW > POS_W) ? CW : POS_W) + 1;

  // storage
  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata_q;
  logic             rd_en;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_data;

  // control
  oae_state_e       state_q, state_d;
  oae_op_e          op_q, op_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [AW-1:0]    end_q, end_d;
  logic             p_valid_q;
  logic [AW-1:0]    p_addr_q;
  logic             out_valid_q, out_valid_d;

  // payload
  logic [AW-1:0]       put_addr_q, put_addr_d;
  logic [VAL_W-1:0]    val_q, val_d;
  logic [VAL_W-1:0]    acc_q, acc_d;
  oae_status_e         res_status_q, res_status_d;
  logic [VAL_W-1:0]    res_data_q, res_data_d;
  logic [FOUND_W-1:0]  res_found_q, res_found_d;
  oae_status_e         out_status_q, out_status_d;
  logic [VAL_W-1:0]    out_data_q, out_data_d;
  logic [FOUND_W-1:0]  out_found_q, out_found_d;
  logic [COUNT_W-1:0]  out_count_q, out_count_d;
  logic                out_last_q, out_last_d;

  logic                accept;
  logic                out_free;
  logic                last_issue;
  logic                match;
  logic [POS_W-1:0]    in_pos;
  logic [VAL_W-1:0]    in_val;
  logic [PW-1:0]       pos_w;
  logic [PW-1:0]       n_w;
  logic [FOUND_W-1:0]  hit_pos;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept     = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free   = !out_valid_q || m_axis_tready_i;
  assign last_issue = (idx_q == end_q);
  assign match      = p_valid_q && (rdata_q == val_q);
  assign in_pos     = s_axis_tdata_i[POS_W-1:0];
  assign in_val     = s_axis_tdata_i[POS_W +: VAL_W];
  assign pos_w      = PW'(in_pos);
  assign n_w        = PW'(count_q);
  assign hit_pos    = FOUND_W'(AW1'(p_addr_q) + AW1'(1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (s_axis_tuser_i)
            OP_INSERT: begin
              if (count_q == CW'(CAPACITY) || in_pos == '0 || pos_w > n_w + PW'(1)) begin
                state_d = S_FIN;
              end else if (pos_w == n_w + PW'(1)) begin
                state_d = S_PUT;
              end else begin
                state_d = S_WALK;
              end
            end
            OP_DELETE: begin
              if (in_pos == '0 || pos_w >= n_w) begin
                state_d = S_FIN;
              end else begin
                state_d = S_WALK;
              end
            end
            OP_SEARCH, OP_SUM: begin
              state_d = (count_q == '0) ? S_FIN : S_WALK;
            end
            OP_DISPLAY: begin
              state_d = (count_q == '0) ? S_FIN : S_DISP;
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_WALK: begin
        if (op_q == OP_SEARCH && match) begin
          state_d = S_FIN;
        end else if (last_issue) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = (op_q == OP_INSERT) ? S_PUT : S_FIN;
      end
      S_PUT: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_DISP: begin
        if (p_valid_q && p_addr_q == end_q) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_d         = op_q;
    count_d      = count_q;
    idx_d        = idx_q;
    end_d        = end_q;
    put_addr_d   = put_addr_q;
    val_d        = val_q;
    acc_d        = acc_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_found_d  = res_found_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_found_d  = out_found_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = put_addr_q;
    wr_data      = val_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d         = oae_op_e'(s_axis_tuser_i);
          val_d        = in_val;
          acc_d        = '0;
          res_status_d = ST_OK;
          res_data_d   = '0;
          res_found_d  = '0;
          put_addr_d   = AW'(pos_w - PW'(1));
          idx_d        = '0;
          end_d        = AW'(count_q - CW'(1));
          unique case (s_axis_tuser_i)
            OP_INSERT: begin
              if (count_q == CW'(CAPACITY) || in_pos == '0 || pos_w > n_w + PW'(1)) begin
                res_status_d = ST_BAD;
              end else begin
                count_d = count_q + CW'(1);
                // walk down from the top entry to the insert point
                idx_d   = AW'(count_q - CW'(1));
                end_d   = AW'(pos_w - PW'(1));
              end
            end
            OP_DELETE: begin
              if (in_pos == '0 || pos_w > n_w) begin
                res_status_d = ST_BAD;
              end else begin
                count_d = count_q - CW'(1);
                idx_d   = AW'(pos_w);
              end
            end
            OP_SEARCH: begin
              if (count_q == '0) begin
                res_status_d = ST_NOT_FOUND;
              end
            end
            OP_SUM: begin
            end
            OP_DISPLAY: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
              end
            end
            default: begin
              res_status_d = ST_BAD;
            end
          endcase
        end
      end
      S_WALK, S_DRAIN: begin
        if (state_q == S_WALK) begin
          rd_en = 1'b1;
          idx_d = (op_q == OP_INSERT) ? idx_q - AW'(1) : idx_q + AW'(1);
        end
        // the item read last cycle
        if (p_valid_q) begin
          unique case (op_q)
            OP_INSERT: begin
              wr_en   = 1'b1;
              wr_addr = p_addr_q + AW'(1);
              wr_data = rdata_q;
            end
            OP_DELETE: begin
              wr_en   = 1'b1;
              wr_addr = p_addr_q - AW'(1);
              wr_data = rdata_q;
            end
            OP_SEARCH: begin
              if (match) begin
                res_found_d = hit_pos;
              end else if (state_q == S_DRAIN) begin
                res_status_d = ST_NOT_FOUND;
              end
            end
            OP_SUM: begin
              acc_d      = acc_q + rdata_q;
              res_data_d = acc_q + rdata_q;
            end
            default: begin
            end
          endcase
        end
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = put_addr_q;
        wr_data = val_q;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_data_d   = res_data_q;
          out_found_d  = res_found_q;
          out_count_d  = COUNT_W'(count_q);
          out_last_d   = 1'b1;
        end
      end
      S_DISP: begin
        // one read in flight; issue only if the result register is free when it lands
        if (!p_valid_q && out_free) begin
          rd_en = 1'b1;
          idx_d = idx_q + AW'(1);
        end
        if (p_valid_q) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_data_d   = rdata_q;
          out_found_d  = '0;
          out_count_d  = COUNT_W'(count_q);
          out_last_d   = (p_addr_q == end_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_INSERT;
      count_q     <= '0;
      idx_q       <= '0;
      end_q       <= '0;
      p_valid_q   <= 1'b0;
      p_addr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      end_q       <= end_d;
      p_valid_q   <= rd_en;
      p_addr_q    <= idx_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    put_addr_q   <= put_addr_d;
    val_q        <= val_d;
    acc_q        <= acc_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_found_q  <= res_found_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_found_q  <= out_found_d;
    out_count_q  <= out_count_d;
    out_last_q   <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[idx_q];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_count_q, out_found_q, out_data_q, out_status_q});

endmodule

`default_nettype wire

/* hw/rtl/oae_checker.sv */
`default_nettype none
`include "ordered_array_engine_macros.svh"

module oae_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tready_o,
  input wire logic                           m_axis_tvalid_o,
  input wire logic                           m_axis_tready_i,
  input wire logic [oae_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input wire logic                           m_axis_tlast_o
);
  import oae_pkg::*;

  logic [STATUS_W-1:0] st;
  logic [VAL_W-1:0]    dat;
  logic [FOUND_W-1:0]  fnd;
  logic [COUNT_W-1:0]  cnt;

  assign st  = m_axis_tdata_o[STATUS_W-1:0];
  assign dat = m_axis_tdata_o[STATUS_W +: VAL_W];
  assign fnd = m_axis_tdata_o[STATUS_W+VAL_W +: FOUND_W];
  assign cnt = m_axis_tdata_o[STATUS_W+VAL_W+FOUND_W +: COUNT_W];

  `OAE_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
  `OAE_ASSERT_HOLDS(a_empty_display, m_axis_tvalid_o && st == ST_EMPTY, m_axis_tlast_o && cnt == '0 && dat == '0)
  `OAE_ASSERT_HOLDS(a_not_found, m_axis_tvalid_o && st == ST_NOT_FOUND, m_axis_tlast_o && fnd == '0)
  `OAE_ASSERT_HOLDS(a_found_ok, m_axis_tvalid_o && fnd != '0, st == ST_OK && m_axis_tlast_o && dat == '0)
  `OAE_ASSERT_HOLDS(a_display_busy, m_axis_tvalid_o && !m_axis_tlast_o, !s_axis_tready_o)

endmodule

bind ordered_array_engine oae_checker u_oae_checker (.*);

`default_nettype wire
